/* rtl/ple_pkg.sv */
`default_nettype none

package ple_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_DEL_FRONT = 3'd2,
        REQ_DEL_BACK  = 3'd3,
        REQ_INS_AT    = 3'd4,
        REQ_DEL_AT    = 3'd5,
        REQ_DUMP      = 3'd6
    } ple_req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } ple_status_t;

    // what a cell loads in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } ple_cell_op_t;

    // controller state
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } ple_state_t;

    // request transfer
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [6:0]         position;
    } ple_in_t;

    // result transfer
    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         count;
        logic signed [31:0] element;
        logic               last;
    } ple_out_t;

endpackage

`default_nettype wire

/* rtl/ple_cell.sv */
`default_nettype none

module ple_cell
    import ple_pkg::*;
(
    input  wire logic               clk,
    input  wire ple_cell_op_t       op,
    input  wire logic signed [31:0] load_value,
    input  wire logic signed [31:0] left_value,
    input  wire logic signed [31:0] right_value,
    output logic signed [31:0]      slot
);

    logic signed [31:0] slot_reg;
    logic signed [31:0] slot_next;

    // pick the source for this slot
    always_comb
    begin
        unique case (op)
            CELL_HOLD:       slot_next = slot_reg;
            CELL_LOAD:       slot_next = load_value;
            CELL_FROM_LEFT:  slot_next = left_value;
            CELL_FROM_RIGHT: slot_next = right_value;
            default:         slot_next = slot_reg;
        endcase
    end

    // slot storage, no reset on payload
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

/* rtl/positional_list_engine.sv */
// positional_list_engine: bounded ordered list of signed 32-bit values.
// Requests arrive on req/req_valid/req_stall; results leave on
// rsp/rsp_valid/rsp_stall. A transfer happens at a clock edge with valid
// high and stall low.
// Insert and delete requests are applied in the cycle of their transfer:
// the cells from the edit position on shift toward their neighbor at once.
// The single result sits in the output register in the next cycle, so such
// requests run at one per cycle while the receiver takes results.
// A dump rotates the ring of CAPACITY cells one step per cycle, holding
// while an emitted result waits on the receiver, and emits the front cell
// for the first count steps, the last one flagged; the remaining steps
// bring the ring back to its starting order. The dump transfer moves the
// controller to the dump state, from which the output register takes the
// first dump result, then one per cycle while the receiver takes results.
// Requests stay stalled during the rotation and while a result is stalled.
// A dump of an empty list gives one result with status list empty.
// When the receiver stalls, the result is held and req_stall goes high
// until the output register frees.
// Reset empties the list (count zero) and clears the result valid;
// slot contents and the result payload are not reset.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire ple_in_t  req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output ple_out_t      rsp
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    ple_state_t state_reg, state_next;
    logic [LW-1:0] length_reg, length_next;
    logic [IW-1:0] step_reg, step_next;
    logic          rsp_valid_reg, rsp_valid_next;
    ple_out_t      rsp_reg, rsp_next;

    logic signed [31:0] cell_data [CAPACITY];
    ple_cell_op_t       cell_op   [CAPACITY];

    logic       out_free;
    logic       accept;
    logic       do_ins;
    logic       do_del;
    logic       start_dump;
    logic       rotate;
    logic       emit;
    logic [6:0] edit_idx;
    logic [6:0] len7;
    logic [6:0] step7;
    logic [1:0] edit_status;
    logic       list_full;
    logic       list_empty;

    assign len7       = 7'(length_reg);
    assign step7      = 7'(step_reg);
    assign list_full  = (length_reg == LW'(CAPACITY));
    assign list_empty = (length_reg == '0);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg != ST_IDLE) || !out_free;
    assign accept     = req_valid && !req_stall;

    // decode the request
    always_comb
    begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        start_dump  = 1'b0;
        edit_idx    = '0;
        edit_status = ST_OK;
        unique case (req.req_type)
            REQ_INS_FRONT:
            begin
                if (list_full) edit_status = ST_FULL;
                else do_ins = 1'b1;
            end
            REQ_INS_BACK:
            begin
                edit_idx = len7;
                if (list_full) edit_status = ST_FULL;
                else do_ins = 1'b1;
            end
            REQ_DEL_FRONT:
            begin
                if (list_empty) edit_status = ST_EMPTY;
                else do_del = 1'b1;
            end
            REQ_DEL_BACK:
            begin
                edit_idx = len7 - 7'd1;
                if (list_empty) edit_status = ST_EMPTY;
                else do_del = 1'b1;
            end
            REQ_INS_AT:
            begin
                edit_idx = req.position - 7'd1;
                if (req.position == 7'd0 || req.position > len7 + 7'd1)
                    edit_status = ST_BADPOS;
                else if (list_full)
                    edit_status = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            REQ_DEL_AT:
            begin
                edit_idx = req.position - 7'd1;
                if (list_empty)
                    edit_status = ST_EMPTY;
                else if (req.position == 7'd0 || req.position > len7)
                    edit_status = ST_BADPOS;
                else
                    do_del = 1'b1;
            end
            REQ_DUMP:
            begin
                if (list_empty) edit_status = ST_EMPTY;
                else start_dump = 1'b1;
            end
            default:
            begin
                edit_status = ST_OK;
            end
        endcase
    end

    // dump stepping: emit while the step is inside the list
    assign emit   = (state_reg == ST_DUMP) && (step7 < len7);
    assign rotate = (state_reg == ST_DUMP) && (!emit || out_free);

    // per-cell operation
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (rotate)
                cell_op[i] = CELL_FROM_RIGHT;
            else if (accept && do_ins && 7'(i) == edit_idx)
                cell_op[i] = CELL_LOAD;
            else if (accept && do_ins && 7'(i) > edit_idx)
                cell_op[i] = CELL_FROM_LEFT;
            else if (accept && do_del && 7'(i) >= edit_idx)
                cell_op[i] = CELL_FROM_RIGHT;
        end
    end

    // ring of slot cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        localparam int LEFT  = (g + CAPACITY - 1) % CAPACITY;
        localparam int RIGHT = (g + 1) % CAPACITY;
        ple_cell u_cell (
            .clk         (clk),
            .op          (cell_op[g]),
            .load_value  (req.value),
            .left_value  (cell_data[LEFT]),
            .right_value (cell_data[RIGHT]),
            .slot        (cell_data[g])
        );
    end

    // controller next state and output register
    always_comb
    begin
        state_next     = state_reg;
        length_next    = length_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (do_ins)
                        length_next = length_reg + LW'(1);
                    else if (do_del)
                        length_next = length_reg - LW'(1);
                    if (start_dump)
                    begin
                        state_next = ST_DUMP;
                        step_next  = '0;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next.status  = edit_status;
                        rsp_next.count   = 7'(length_next);
                        rsp_next.element = '0;
                        rsp_next.last    = 1'b1;
                    end
                end
            end
            ST_DUMP:
            begin
                if (rotate)
                begin
                    step_next = step_reg + IW'(1);
                    if (emit)
                    begin
                        rsp_valid_next   = 1'b1;
                        rsp_next.status  = ST_OK;
                        rsp_next.count   = len7;
                        rsp_next.element = cell_data[0];
                        rsp_next.last    = (step7 == len7 - 7'd1);
                    end
                    if (step_reg == IW'(CAPACITY - 1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_reg    <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // count never exceeds capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(CAPACITY))
        else $error("list length above capacity");

    // no request taken while dumping
    a_dump_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> req_stall)
        else $error("request taken during dump");

    // a result that is not last only comes out of a dump in progress
    a_notlast_dump: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> state_reg == ST_DUMP)
        else $error("non-final result outside a dump");

    // a rejected edit leaves the count unchanged
    a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !do_ins && !do_del |=> $stable(length_reg))
        else $error("count changed on rejected request");

endmodule

`default_nettype wire
